FILE: design/dtdfp_pkg.sv
// Shared types and constants for the date-time digit field parser.
`default_nettype none

package dtdfp_pkg;

   // Result status codes, in check order
   typedef enum logic [2:0] {
      STATUS_OK     = 3'd0,
      STATUS_COUNT  = 3'd1,
      STATUS_YEAR   = 3'd2,
      STATUS_MONTH  = 3'd3,
      STATUS_DAY    = 3'd4,
      STATUS_HOUR   = 3'd5,
      STATUS_MINUTE = 3'd6,
      STATUS_SECOND = 3'd7
   } status_type;

   localparam int unsigned SLOT_COUNT  = 6;
   localparam int unsigned CNT_W       = 3;   // holds 0..SLOT_COUNT
   localparam int unsigned ACC_W       = 14;  // an open run never exceeds RUN_LIMIT
   localparam int unsigned SUM_W       = 17;  // RUN_LIMIT * 10 + 9 fits
   localparam int unsigned NUM_W       = 16;

   localparam logic [SUM_W-1:0] RUN_LIMIT   = 17'd9999;
   localparam logic [NUM_W-1:0] YEAR_SHORT  = 16'd100;
   localparam logic [NUM_W-1:0] YEAR_BASE   = 16'd2000;
   localparam logic [NUM_W-1:0] YEAR_MAX    = 16'd2100;
   localparam logic [7:0]       MONTH_MAX   = 8'd12;
   localparam logic [7:0]       DAY_MAX     = 8'd31;
   localparam logic [7:0]       HOUR_MAX    = 8'd23;
   localparam logic [7:0]       MINUTE_MAX  = 8'd59;
   localparam logic [7:0]       SECOND_MAX  = 8'd59;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

endpackage

`default_nettype wire

FILE: design/datetime_digit_field_parser_unit.sv
// Top level of the date-time digit field parser: character register, parse state, result register.
// A character is held in the character register; a last character's result then loads the
// result register. Throughput: one character per cycle while the character register does not stall.
// The character register stalls only when a last character meets a full, stalled result register.
// Reset (synchronous, active high) empties both registers and clears the digit run and count.
// After each result the parse state returns to its reset values for the next string.
`default_nettype none

module datetime_digit_field_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_is_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_year_out,
   output logic [7:0]       rsp_month_out,
   output logic [7:0]       rsp_day_out,
   output logic [7:0]       rsp_hour_out,
   output logic [7:0]       rsp_minute_out,
   output logic [7:0]       rsp_second_out
);

   localparam int unsigned FC  = dtdfp_pkg::SLOT_COUNT;
   localparam int unsigned CW  = dtdfp_pkg::CNT_W;
   localparam int unsigned AW  = dtdfp_pkg::ACC_W;
   localparam int unsigned SW  = dtdfp_pkg::SUM_W;
   localparam int unsigned NW  = dtdfp_pkg::NUM_W;
   localparam logic [CW-1:0] FC_CNT = CW'(FC);

   // character register
   logic          char_valid_ff, char_valid_in;
   logic [7:0]    char_ff;
   logic          last_ff;
   logic          char_fire;
   logic          char_load;

   // parse state
   logic          in_number_ff, in_number_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [CW-1:0] found_ff, found_in;
   logic [NW-1:0] store_ff [FC];

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   dtdfp_pkg::status_type status_ff, status_in;
   logic [NW-1:0] year_ff, year_in;
   logic [7:0]    month_ff, month_in;
   logic [7:0]    day_ff, day_in;
   logic [7:0]    hour_ff, hour_in;
   logic [7:0]    minute_ff, minute_in;
   logic [7:0]    second_ff, second_in;

   // per-character datapath
   logic          active;
   logic          is_digit;
   logic [AW-1:0] base;
   logic [SW-1:0] sum;
   logic          over_limit;
   logic          close_char;
   logic          run_open;
   logic          close_any;
   logic [NW-1:0] close_val;
   logic [NW-1:0] view [FC];
   logic [NW-1:0] year_val;
   logic          count_ok;

   // handshake: a last character needs room in the result register
   assign char_fire = char_valid_ff && (!last_ff || !rsp_valid_ff || !rsp_stall);
   assign char_load = !char_valid_ff || char_fire;
   assign req_stall = !char_load;
   assign char_valid_in = req_valid ? 1'b1 : (char_fire ? 1'b0 : char_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         char_valid_ff <= 1'b0;
      end else begin
         char_valid_ff <= char_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (char_load && req_valid) begin
         char_ff <= req_ch;
         last_ff <= req_is_last;
      end
   end

   // digit accumulate and close decisions
   always_comb begin
      active     = found_ff < FC_CNT;
      is_digit   = (char_ff >= dtdfp_pkg::CHAR_ZERO) && (char_ff <= dtdfp_pkg::CHAR_NINE);
      base       = in_number_ff ? acc_ff : '0;
      sum        = SW'(base) * SW'(10) + SW'(char_ff[3:0]);
      over_limit = sum > dtdfp_pkg::RUN_LIMIT;
      close_char = active && ((is_digit && over_limit) || (!is_digit && in_number_ff));
      run_open   = active && is_digit && !over_limit;
      close_any  = close_char || (last_ff && run_open);
      if (close_char) begin
         close_val = is_digit ? sum[NW-1:0] : NW'(acc_ff);
      end else begin
         close_val = NW'(sum[AW-1:0]);
      end
   end

   // next parse state
   always_comb begin
      in_number_in = in_number_ff;
      acc_in       = acc_ff;
      found_in     = found_ff;
      if (char_fire) begin
         if (last_ff) begin
            in_number_in = 1'b0;
            acc_in       = '0;
            found_in     = '0;
         end else begin
            in_number_in = active ? run_open : in_number_ff;
            acc_in       = run_open ? sum[AW-1:0] : (active ? '0 : acc_ff);
            found_in     = found_ff + CW'(close_char);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_number_ff <= 1'b0;
         acc_ff       <= '0;
         found_ff     <= '0;
      end else begin
         in_number_ff <= in_number_in;
         acc_ff       <= acc_in;
         found_ff     <= found_in;
      end
   end

   // store a closed number at the next free slot
   always_ff @(posedge clock) begin
      if (char_fire && close_any) begin
         store_ff[found_ff] <= close_val;
      end
   end

   // stored numbers as they stand after this character
   always_comb begin
      for (int i = 0; i < FC; i++) begin
         view[i] = (close_any && (found_ff == CW'(i))) ? close_val : store_ff[i];
      end
      count_ok = (found_ff + CW'(close_any)) == FC_CNT;
      year_val = (view[0] < dtdfp_pkg::YEAR_SHORT) ? view[0] + dtdfp_pkg::YEAR_BASE : view[0];
   end

   // range checks in priority order
   always_comb begin
      year_in   = year_val;
      month_in  = view[1][7:0];
      day_in    = view[2][7:0];
      hour_in   = view[3][7:0];
      minute_in = view[4][7:0];
      second_in = view[5][7:0];
      if (!count_ok) begin
         status_in = dtdfp_pkg::STATUS_COUNT;
         year_in   = '0;
         month_in  = '0;
         day_in    = '0;
         hour_in   = '0;
         minute_in = '0;
         second_in = '0;
      end else if ((year_val < dtdfp_pkg::YEAR_BASE) || (year_val > dtdfp_pkg::YEAR_MAX)) begin
         status_in = dtdfp_pkg::STATUS_YEAR;
      end else if ((month_in == 8'd0) || (month_in > dtdfp_pkg::MONTH_MAX)) begin
         status_in = dtdfp_pkg::STATUS_MONTH;
      end else if ((day_in == 8'd0) || (day_in > dtdfp_pkg::DAY_MAX)) begin
         status_in = dtdfp_pkg::STATUS_DAY;
      end else if (hour_in > dtdfp_pkg::HOUR_MAX) begin
         status_in = dtdfp_pkg::STATUS_HOUR;
      end else if (minute_in > dtdfp_pkg::MINUTE_MAX) begin
         status_in = dtdfp_pkg::STATUS_MINUTE;
      end else if (second_in > dtdfp_pkg::SECOND_MAX) begin
         status_in = dtdfp_pkg::STATUS_SECOND;
      end else begin
         status_in = dtdfp_pkg::STATUS_OK;
      end
   end

   // result register: load on a last character, drop on transfer
   assign rsp_valid_in = (char_fire && last_ff) ? 1'b1 :
                         ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (char_fire && last_ff) begin
         status_ff <= status_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_year_out   = year_ff;
   assign rsp_month_out  = month_ff;
   assign rsp_day_out    = day_ff;
   assign rsp_hour_out   = hour_ff;
   assign rsp_minute_out = minute_ff;
   assign rsp_second_out = second_ff;

   // checks on the parse state
   a_found_range: assert property (@(posedge clock) disable iff (reset)
      found_ff <= FC_CNT)
      else $error("number count beyond six");

   a_open_run_bounded: assert property (@(posedge clock) disable iff (reset)
      in_number_ff |-> ((SW'(acc_ff) <= dtdfp_pkg::RUN_LIMIT) && (found_ff < FC_CNT)))
      else $error("open run beyond limit or after six numbers");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (char_fire && last_ff) |=> (!in_number_ff && (found_ff == '0) && rsp_valid_ff))
      else $error("parse state not cleared after result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(char_fire && last_ff))
      else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: bench/tb_datetime_digit_field_parser_unit.sv
// Self-checking testbench for the date-time digit field parser unit.
`timescale 1ns / 100ps

module tb_datetime_digit_field_parser_unit;

   localparam int          HALF_PERIOD    = 1;
   localparam int          RESET_CYCLES   = 7;
   localparam int          HOLDOFF_CYCLES = 400;
   localparam int          DRAIN_LIMIT    = 2000;
   localparam int          SETTLE_CYCLES  = 4;

   // One parsed date-time as the block presents it
   typedef struct {
      dtdfp_pkg::status_type status;
      logic [15:0] year;
      logic [7:0]  month;
      logic [7:0]  day;
      logic [7:0]  hour;
      logic [7:0]  minute;
      logic [7:0]  second;
   } datetime_fields_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch      = 8'h00;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_year_out;
   logic [7:0]  rsp_month_out;
   logic [7:0]  rsp_day_out;
   logic [7:0]  rsp_hour_out;
   logic [7:0]  rsp_minute_out;
   logic [7:0]  rsp_second_out;

   // Parse state of the predictor
   logic        digit_run_open;
   logic [16:0] digit_run_value;
   logic [2:0]  numbers_held;
   logic [15:0] held_number [dtdfp_pkg::SLOT_COUNT];

   datetime_fields_type pending_datetimes [$];

   int unsigned mismatches     = 0;
   int unsigned chars_sent     = 0;
   int unsigned results_seen   = 0;
   int unsigned req_stall_hits = 0;
   int unsigned status_hits [8];
   bit          req_gaps_on    = 1'b1;
   bit          offer_high     = 1'b0;
   logic        rsp_gaps_on    = 1'b1;
   int unsigned holdoff_seq    = 0;

   datetime_digit_field_parser_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ch         (req_ch),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_year_out   (rsp_year_out),
      .rsp_month_out  (rsp_month_out),
      .rsp_day_out    (rsp_day_out),
      .rsp_hour_out   (rsp_hour_out),
      .rsp_minute_out (rsp_minute_out),
      .rsp_second_out (rsp_second_out)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------- prediction

   function automatic void clear_parse();
      digit_run_open  = 1'b0;
      digit_run_value = '0;
      numbers_held    = '0;
      foreach (held_number[i]) held_number[i] = '0;
   endfunction

   // Store the open run as a number while there is room, then close it
   function automatic void close_run();
      if (numbers_held < dtdfp_pkg::SLOT_COUNT) begin
         held_number[numbers_held] = digit_run_value[15:0];
         numbers_held = numbers_held + 3'd1;
      end
      digit_run_open  = 1'b0;
      digit_run_value = '0;
   endfunction

   // Advance the parse by one character; queue the date-time on the last one
   function automatic void parse_char(input logic [7:0] c, input logic last);
      datetime_fields_type fields;
      logic [15:0]         year;
      if (numbers_held < dtdfp_pkg::SLOT_COUNT) begin
         if (c >= dtdfp_pkg::CHAR_ZERO && c <= dtdfp_pkg::CHAR_NINE) begin
            if (!digit_run_open) begin
               digit_run_open  = 1'b1;
               digit_run_value = '0;
            end
            digit_run_value = 17'(digit_run_value * 10 + (c - dtdfp_pkg::CHAR_ZERO));
            if (digit_run_value > dtdfp_pkg::RUN_LIMIT) close_run();
         end else if (digit_run_open) begin
            close_run();
         end
      end
      if (last) begin
         if (digit_run_open) close_run();
         fields.status = dtdfp_pkg::STATUS_COUNT;
         fields.year   = '0;
         fields.month  = '0;
         fields.day    = '0;
         fields.hour   = '0;
         fields.minute = '0;
         fields.second = '0;
         if (numbers_held == dtdfp_pkg::SLOT_COUNT) begin
            year = held_number[0];
            if (year < dtdfp_pkg::YEAR_SHORT) year = year + dtdfp_pkg::YEAR_BASE;
            fields.year   = year;
            fields.month  = held_number[1][7:0];
            fields.day    = held_number[2][7:0];
            fields.hour   = held_number[3][7:0];
            fields.minute = held_number[4][7:0];
            fields.second = held_number[5][7:0];
            if (year < dtdfp_pkg::YEAR_BASE || year > dtdfp_pkg::YEAR_MAX)
               fields.status = dtdfp_pkg::STATUS_YEAR;
            else if (fields.month < 8'd1 || fields.month > dtdfp_pkg::MONTH_MAX)
               fields.status = dtdfp_pkg::STATUS_MONTH;
            else if (fields.day < 8'd1 || fields.day > dtdfp_pkg::DAY_MAX)
               fields.status = dtdfp_pkg::STATUS_DAY;
            else if (fields.hour > dtdfp_pkg::HOUR_MAX)
               fields.status = dtdfp_pkg::STATUS_HOUR;
            else if (fields.minute > dtdfp_pkg::MINUTE_MAX)
               fields.status = dtdfp_pkg::STATUS_MINUTE;
            else if (fields.second > dtdfp_pkg::SECOND_MAX)
               fields.status = dtdfp_pkg::STATUS_SECOND;
            else
               fields.status = dtdfp_pkg::STATUS_OK;
         end
         pending_datetimes.push_back(fields);
         clear_parse();
      end
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // Mostly back-to-back, sometimes a short gap, rarely a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] pick_separator();
      logic [7:0] c;
      case ($urandom_range(0, 7))
         0: c = "-";
         1: c = "/";
         2: c = ":";
         3: c = "T";
         4: c = " ";
         5: c = ".";
         default: begin
            do c = 8'($urandom_range(0, 255));
            while (c >= dtdfp_pkg::CHAR_ZERO && c <= dtdfp_pkg::CHAR_NINE);
         end
      endcase
      return c;
   endfunction

   // Value for one date-time field, inside its range or deliberately outside
   function automatic int unsigned pick_field_value(input int slot, input bit out_of_range);
      int unsigned lo_v [dtdfp_pkg::SLOT_COUNT] = '{2000, 1, 1, 0, 0, 0};
      int unsigned hi_v [dtdfp_pkg::SLOT_COUNT] = '{2100, 12, 31, 23, 59, 59};
      if (!out_of_range) begin
         if (slot == 0 && $urandom_range(0, 1) == 1) return $urandom_range(0, 99);
         return $urandom_range(lo_v[slot], hi_v[slot]);
      end
      case ($urandom_range(0, 3))
         0:       return hi_v[slot] + 1;
         1:       return (lo_v[slot] > 0) ? lo_v[slot] - 1 : 9999;
         2:       return $urandom_range(hi_v[slot] + 1, 999);
         default: return $urandom_range(0, 9999);
      endcase
   endfunction

   function automatic void append_number(ref logic [7:0] text[$], input int unsigned value,
                                         input int unsigned min_digits);
      logic [7:0]  digits[$];
      int unsigned rest;
      rest = value;
      do begin
         digits.push_front(8'(dtdfp_pkg::CHAR_ZERO + rest % 10));
         rest = rest / 10;
      end while (rest != 0 || digits.size() < min_digits);
      foreach (digits[i]) text.push_back(digits[i]);
   endfunction

   // Date-time text with random content: mostly six fields, sometimes fewer,
   // extra, over-long or out of range, sometimes with junk after the fields
   function automatic void build_datetime(ref logic [7:0] text[$]);
      int unsigned shape, count, bad_slot, long_slot;
      text.delete();
      shape     = $urandom_range(0, 99);
      count     = (shape < 10) ? $urandom_range(1, 5) :
                  (shape < 20) ? $urandom_range(7, 8) : dtdfp_pkg::SLOT_COUNT;
      bad_slot  = ($urandom_range(0, 2) == 0) ?
                  $urandom_range(0, dtdfp_pkg::SLOT_COUNT - 1) : dtdfp_pkg::SLOT_COUNT;
      long_slot = (shape >= 20 && shape < 30) ? $urandom_range(0, count - 1) : count;
      if ($urandom_range(0, 7) == 0) text.push_back(pick_separator());
      for (int slot = 0; slot < count; slot++) begin
         if (slot > 0) repeat ($urandom_range(1, 2)) text.push_back(pick_separator());
         if (slot == long_slot)
            append_number(text, $urandom_range(10000, 99999), 5);
         else
            append_number(text,
                          pick_field_value(slot % dtdfp_pkg::SLOT_COUNT, slot == bad_slot),
                          $urandom_range(1, (slot == 0) ? 4 : 2));
      end
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic hold_sender();
      if (offer_high) begin
         req_valid <= 1'b0;
         offer_high = 1'b0;
      end
   endtask

   // Offer one character until it transfers, predict, then sometimes idle a while
   task automatic send_char(input logic [7:0] c, input logic last);
      int unsigned gap;
      req_ch      <= c;
      req_is_last <= last;
      if (!offer_high) begin
         req_valid <= 1'b1;
         offer_high = 1'b1;
      end
      do begin
         @(posedge clock);
         if (req_stall) req_stall_hits++;
      end while (req_stall);
      chars_sent++;
      parse_char(c, last);
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         hold_sender();
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_bytes(input logic [7:0] text[$]);
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // ---------------------------------------------------------------- tests

   // Byte extremes and null as lone characters, a valid two-digit year on a
   // closing digit, and a run that passes the limit and splits
   task automatic test_directed();
      send_char(8'hFF, 1'b1);
      send_char(8'h00, 1'b1);
      send_text("0,1,31,23,59,59");
      send_text("1234567");
   endtask

   task automatic test_well_formed(input int unsigned budget);
      logic [7:0]  text[$];
      int unsigned stop_at;
      stop_at = chars_sent + budget;
      while (chars_sent < stop_at) begin
         build_datetime(text);
         send_bytes(text);
      end
   endtask

   // Run both sides flat out
   task automatic test_full_rate(input int unsigned budget);
      req_gaps_on = 1'b0;
      rsp_gaps_on <= 1'b0;
      test_well_formed(budget);
      req_gaps_on = 1'b1;
      rsp_gaps_on <= 1'b1;
   endtask

   // Hold off the receiver while short strings keep arriving, so the block
   // backs up and stalls its input
   task automatic test_result_holdoff();
      logic [7:0] text[$];
      req_gaps_on = 1'b0;
      holdoff_seq <= holdoff_seq + 1;
      repeat (30) begin
         text.delete();
         repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
         send_bytes(text);
      end
      req_gaps_on = 1'b1;
   endtask

   // Random bytes dense in digits, and well-formed strings cut short
   task automatic test_noise(input int unsigned budget);
      logic [7:0]  text[$];
      int unsigned stop_at;
      stop_at = chars_sent + budget;
      while (chars_sent < stop_at) begin
         if ($urandom_range(0, 1) == 0) begin
            build_datetime(text);
            text = text[0:$urandom_range(0, text.size() - 1)];
         end else begin
            text.delete();
            repeat ($urandom_range(1, 24))
               text.push_back(($urandom_range(0, 1) == 0) ?
                              8'(dtdfp_pkg::CHAR_ZERO + $urandom_range(0, 9)) :
                              8'($urandom_range(0, 255)));
         end
         send_bytes(text);
      end
   endtask

   // ---------------------------------------------------------------- result side

   // Random stall on the result channel, or a long counted hold-off on request
   always @(posedge clock) begin : drive_rsp_stall
      int unsigned stall_left;
      int unsigned holdoff_seen;
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_left   = 0;
         holdoff_seen = holdoff_seq;
      end else if (holdoff_seen != holdoff_seq) begin
         holdoff_seen = holdoff_seq;
         stall_left   = HOLDOFF_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void compare_field(input string field, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      end
   endfunction

   // Check each transfer on the result channel against the oldest prediction
   always @(posedge clock) begin : check_results
      datetime_fields_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         status_hits[rsp_status]++;
         if (pending_datetimes.size() == 0) begin
            mismatches++;
            $display("%0t ns: result with status %0d arrived with nothing expected",
                     $time, rsp_status);
         end else begin
            want = pending_datetimes.pop_front();
            compare_field("status",     want.status, rsp_status);
            compare_field("year_out",   want.year,   rsp_year_out);
            compare_field("month_out",  want.month,  rsp_month_out);
            compare_field("day_out",    want.day,    rsp_day_out);
            compare_field("hour_out",   want.hour,   rsp_hour_out);
            compare_field("minute_out", want.minute, rsp_minute_out);
            compare_field("second_out", want.second, rsp_second_out);
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin : run_tests
      string                 status_line;
      dtdfp_pkg::status_type status_name;
      clear_parse();
      reset <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_well_formed(950);
      test_result_holdoff();
      test_full_rate(250);
      test_noise(400);
      test_well_formed(150);
      hold_sender();

      // Drain what is still on its way, then let the pipeline settle
      for (int n = 0; n < DRAIN_LIMIT && pending_datetimes.size() != 0; n++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_datetimes.size() != 0) begin
         mismatches += pending_datetimes.size();
         $display("%0t ns: %0d expected results never arrived", $time,
                  pending_datetimes.size());
      end

      status_line = "";
      foreach (status_hits[i]) begin
         status_name = dtdfp_pkg::status_type'(i);
         status_line = {status_line, $sformatf(" %s=%0d", status_name.name(), status_hits[i])};
      end
      $display("Covered %0d characters, %0d results, %0d input stall cycles.",
               chars_sent, results_seen, req_stall_hits);
      $display("Results by status:%s", status_line);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
design/dtdfp_pkg.sv
design/datetime_digit_field_parser_unit.sv
bench/tb_datetime_digit_field_parser_unit.sv
